[rtl/tdpt_pkg.sv]
package tdpt_pkg;

    // Width of the candidate port.
    localparam int CAND_WIDTH = 32;

    // Default width of the value that is actually tested.
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_FINISH
    } t_state;

endpackage

[rtl/trial_division_prime_test.sv]
// Primality tester by trial division. An item is one unsigned candidate on
// i_candidate. Only its low VALUE_WIDTH bits are tested; when VALUE_WIDTH is
// wider than the port, the upper bits are zero. Each item gives one result
// item on o_is_prime: 1 if the value is prime, 0 otherwise. Zero, one and
// even values other than two are settled in the cycle after acceptance. An
// odd value of three or more is divided by the odd divisors 3, 5, 7, ... in
// turn. One restoring divider, a single subtract-and-compare unit that
// produces one quotient bit per cycle, does all the work; every divisor
// costs VALUE_WIDTH divide steps and one check. The walk ends at the first
// divisor that divides exactly, or once the divisor exceeds the quotient,
// which means the divisor squared exceeds the value. The number of
// divisors tried is at most about sqrt(value) / 2, about 32768 for a
// 32-bit prime near the top of the range; most composites finish far
// sooner. The block takes one item at a time: o_ready is high only while
// the sequencer is idle. The result sits in an output register, so a new
// item can be accepted while the previous result still waits to be taken.
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [tdpt_pkg::CAND_WIDTH-1:0] i_candidate,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_is_prime
);

    localparam int CW = $clog2(VALUE_WIDTH);

    tdpt_pkg::t_state r_state, n_state;

    // Value under test, the current trial divisor, and the divider's
    // quotient and partial remainder registers.
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [VALUE_WIDTH-1:0] r_div,   n_div;
    logic [VALUE_WIDTH-1:0] r_quo,   n_quo;
    logic [VALUE_WIDTH-1:0] r_rem,   n_rem;
    logic [CW-1:0]          r_bit_cnt, n_bit_cnt;

    // Pending result inside the sequencer, and the output register.
    logic r_result,    n_result;
    logic r_out_valid, n_out_valid;
    logic r_out_prime, n_out_prime;

    logic [VALUE_WIDTH-1:0] in_value;
    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   rem_diff;
    logic                   quo_bit;

    assign in_value = VALUE_WIDTH'(i_candidate);

    // One restoring divide step: shift in the next dividend bit and try to
    // subtract the divisor. A borrow in the top bit means the divisor did
    // not fit.
    assign rem_shift = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, r_div};
    assign quo_bit   = ~rem_diff[VALUE_WIDTH];

    assign o_ready    = (r_state == tdpt_pkg::ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_out_prime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_value     <= n_value;
        r_div       <= n_div;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_bit_cnt   <= n_bit_cnt;
        r_result    <= n_result;
        r_out_prime <= n_out_prime;
    end

    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_div       = r_div;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_bit_cnt   = r_bit_cnt;
        n_result    = r_result;
        n_out_prime = r_out_prime;
        n_out_valid = r_out_valid;

        // The output register empties when the result item is taken.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            tdpt_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_value   = in_value;
                    n_div     = VALUE_WIDTH'(3);
                    n_quo     = in_value;
                    n_rem     = '0;
                    n_bit_cnt = CW'(VALUE_WIDTH - 1);
                    // Values below two and even values are settled at once;
                    // two is the only even prime.
                    if (in_value[VALUE_WIDTH-1:1] == '0) begin
                        n_result = 1'b0;
                        n_state  = tdpt_pkg::ST_FINISH;
                    end else if (in_value == VALUE_WIDTH'(2)) begin
                        n_result = 1'b1;
                        n_state  = tdpt_pkg::ST_FINISH;
                    end else if (!in_value[0]) begin
                        n_result = 1'b0;
                        n_state  = tdpt_pkg::ST_FINISH;
                    end else begin
                        n_state  = tdpt_pkg::ST_DIVIDE;
                    end
                end
            end

            tdpt_pkg::ST_DIVIDE: begin
                n_rem = quo_bit ? rem_diff[VALUE_WIDTH-1:0]
                                : rem_shift[VALUE_WIDTH-1:0];
                n_quo = {r_quo[VALUE_WIDTH-2:0], quo_bit};
                if (r_bit_cnt == '0) begin
                    n_state = tdpt_pkg::ST_CHECK;
                end else begin
                    n_bit_cnt = r_bit_cnt - CW'(1);
                end
            end

            tdpt_pkg::ST_CHECK: begin
                // A divisor above the quotient means its square exceeds the
                // value, so no factor remains to be found.
                if (r_div > r_quo) begin
                    n_result = 1'b1;
                    n_state  = tdpt_pkg::ST_FINISH;
                end else if (r_rem == '0) begin
                    n_result = 1'b0;
                    n_state  = tdpt_pkg::ST_FINISH;
                end else begin
                    n_div     = r_div + VALUE_WIDTH'(2);
                    n_quo     = r_value;
                    n_rem     = '0;
                    n_bit_cnt = CW'(VALUE_WIDTH - 1);
                    n_state   = tdpt_pkg::ST_DIVIDE;
                end
            end

            tdpt_pkg::ST_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_result;
                    n_state     = tdpt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[bench/prime_result_checker.sv]
module prime_result_checker #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [tdpt_pkg::CAND_WIDTH-1:0] i_candidate,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_is_prime,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [tdpt_pkg::CAND_WIDTH-1:0] candidate;
        logic                            is_prime;
    } t_verdict;

    t_verdict verdict_q[$];

    // Only the low VALUE_WIDTH bits of the candidate take part in the test.
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

    // Trial division by odd divisors; d <= v / d avoids overflow of d * d.
    function automatic logic primality_by_division(input logic [63:0] value);
        logic [63:0] divisor;
        if (value < 64'd2) return 1'b0;
        if (value == 64'd2) return 1'b1;
        if (value[0] == 1'b0) return 1'b0;
        for (divisor = 64'd3; divisor <= value / divisor; divisor += 64'd2) begin
            if (value % divisor == 64'd0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Both counters are two-state and start at zero.
    always @(posedge i_clk) begin
        t_verdict expected;
        t_verdict fresh;
        if (i_rst_n) begin
            // The result is always older than an item accepted on the same edge.
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual is_prime=%0b",
                             $realtime, i_is_prime);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    expected = verdict_q.pop_front();
                    if (i_is_prime !== expected.is_prime) begin
                        $display("%0t: is_prime mismatch for candidate %0d: expected %0b, actual %0b",
                                 $realtime, expected.candidate, expected.is_prime, i_is_prime);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                fresh.candidate = i_candidate;
                fresh.is_prime = primality_by_division({32'd0, i_candidate} & VALUE_MASK);
                verdict_q.push_back(fresh);
            end
            o_pending <= verdict_q.size();
        end
    end

endmodule

[bench/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // A quiet stretch longer than this means the block has hung. The slowest
    // item offered here is a prime near 2^20, and the longest receiver hold-off
    // is set by RX_HOLD_CYCLES.
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS   = 120;
    localparam int DRAIN_CYCLES   = 50;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [tdpt_pkg::CAND_WIDTH-1:0] i_candidate = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic                            o_is_prime;

    int fail_count;
    int pending_results;

    // Set by the stimulus to ask the receiver for one long hold-off.
    bit rx_hold_req = 1'b0;
    // While set, the receiver takes every result at once.
    bit rx_steady = 1'b0;

    trial_division_prime_test uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_candidate (i_candidate),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_is_prime  (o_is_prime)
    );

    prime_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_candidate  (i_candidate),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_is_prime   (o_is_prime),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Idle gaps: mostly none or short, now and then a long one.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // Random candidates. Trial division of a prime costs about sqrt(value) / 2
    // divisors, so most values stay below 2^16 and only a few reach 2^20.
    // The upper bits are exercised with even values and with multiples of a
    // small odd prime, which the block settles within a few divisors.
    function automatic logic [31:0] random_candidate();
        int unsigned small_factors[5];
        int unsigned factor;
        int          roll;
        small_factors = '{3, 5, 7, 11, 13};
        roll = $urandom_range(0, 99);
        if (roll < 15) return $urandom_range(0, 64);
        if (roll < 60) return $urandom_range(0, 65535);
        if (roll < 67) return $urandom_range(65536, 1 << 20);
        if (roll < 82) return $urandom & 32'hFFFF_FFFE;
        factor = small_factors[$urandom_range(0, 4)];
        return factor * ($urandom % (32'hFFFF_FFFF / factor));
    endfunction

    // Offers one item after an optional gap and returns on the edge that
    // accepts it. With no gap, valid simply stays high from the last item.
    task automatic offer_candidate(input logic [31:0] value, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_candidate <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Holds the input side idle until every outstanding result has been taken.
    task automatic await_all_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls of varied length, a long hold-off on request,
    // and steady acceptance while rx_steady is set.
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_steady) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                stall = idle_gap();
                if (stall > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves an item for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        logic [31:0] directed_values[$];

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items: zero and one, two, other even values, small primes,
        // squares of primes where the last divisor squared equals the value,
        // a product of two close primes, a prime near 2^20, and values that
        // set the upper bits, all of them with small factors.
        directed_values = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25,
            32'd49, 32'd97, 32'd65521, 32'd65535, 32'd65536, 32'd1018081,
            32'd1022117, 32'd1000003, 32'h8000_0000, 32'hFFFF_FFFE,
            32'hFFFF_FFFF, 32'hAAAA_AAAB, 32'h5555_5555
        };
        foreach (directed_values[idx]) offer_candidate(directed_values[idx], idle_gap());

        // Let everything drain, then hold the receiver off while cheap items
        // keep coming, so the output register fills and the input stalls.
        await_all_results();
        rx_hold_req = 1'b1;
        repeat (6) offer_candidate($urandom_range(0, 40), 0);
        await_all_results();

        // Random items. One stretch runs with no idling on either side, and
        // the sender pauses after 80 items until every result is back.
        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            rx_steady = (item >= 40 && item < 60);
            if (item == 80) await_all_results();
            offer_candidate(random_candidate(), rx_steady ? 0 : idle_gap());
        end
        rx_steady = 1'b0;

        await_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
